>>> rtl/core/gcd_pkg.sv
// Shared types, fixed-point constants and the arctangent table of the great-circle block.
package gcd_pkg;

  localparam int unsigned ANGLE_FRAC_BITS_DEF = 29;
  localparam int unsigned CORDIC_STEPS_DEF    = 32;

  localparam int unsigned COORD_W  = 32;
  localparam int unsigned RADIUS_W = 23;
  localparam int unsigned DIST_W   = 25;
  // angle accumulator, Q.32
  localparam int unsigned ZW = 36;
  // rotation x/y, Q.30
  localparam int unsigned RW = 33;
  // vectoring x/y and products, Q.30
  localparam int unsigned VW = 36;
  // clamped central angle, unsigned Q.32
  localparam int unsigned CW = 34;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 23'd6370949;
  localparam logic signed [ZW-1:0] PI_Q32      = 36'sd13493037705;
  localparam logic signed [ZW-1:0] HALF_PI_Q32 = 36'sd6746518852;
  localparam logic signed [ZW-1:0] TWO_PI_Q32  = 36'sd26986075410;
  localparam logic signed [VW-1:0] INV_GAIN_Q30 = 36'sd652032874;
  localparam logic signed [VW-1:0] AZ_TOL       = 36'sd16;
  localparam logic [DIST_W-1:0] MAX_DIST        = 25'd26353586;

  typedef struct packed {
    logic signed [COORD_W-1:0] start_lat;
    logic signed [COORD_W-1:0] start_lon;
    logic signed [COORD_W-1:0] end_lat;
    logic signed [COORD_W-1:0] end_lon;
  } gcd_in_t;

  typedef struct packed {
    logic [DIST_W-1:0]         path_distance_m;
    logic signed [COORD_W-1:0] initial_azimuth;
  } gcd_out_t;

  // atan(2^-step) in Q.32, rounded to nearest
  function automatic logic signed [ZW-1:0] atan_q32(input int unsigned step);
    logic signed [ZW-1:0] v;
    v = '0;
    case (step)
      0:  v = 36'sd3373259426;
      1:  v = 36'sd1991351318;
      2:  v = 36'sd1052175346;
      3:  v = 36'sd534100635;
      4:  v = 36'sd268086748;
      5:  v = 36'sd134174063;
      6:  v = 36'sd67103403;
      7:  v = 36'sd33553749;
      8:  v = 36'sd16777131;
      9:  v = 36'sd8388597;
      10: v = 36'sd4194303;
      default: begin
        // small angles: atan(x) rounds to x, the half-unit entry rounds up
        if (step <= 32) begin
          v = ZW'(64'd1 << (32 - step));
        end else if (step == 33) begin
          v = 36'sd1;
        end
      end
    endcase
    return v;
  endfunction

  // Q.30 product, rounded half up
  function automatic logic signed [VW-1:0] mulq(input logic signed [VW-1:0] a,
                                               input logic signed [VW-1:0] b);
    logic signed [2*VW-1:0] p;
    p = a * b + ((2*VW)'(1) <<< 29);
    return VW'(p >>> 30);
  endfunction

endpackage

>>> rtl/core/gcd_mod_cell.sv
// One restoring step of the angle reduction: subtract a shifted multiple of two pi.
module gcd_mod_cell
  import gcd_pkg::*;
#(
  parameter int unsigned W     = 37,
  parameter int unsigned SHIFT = 0
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] rem_i,
  input  logic         sgn_i,
  output logic [W-1:0] rem_o,
  output logic         sgn_o
);

  localparam logic [W-1:0] STEP_VAL = W'(TWO_PI_Q32) << SHIFT;

  logic [W-1:0] rem_q;
  logic         sgn_q;

  // subtract when the remainder still holds this multiple
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= (rem_i >= STEP_VAL) ? rem_i - STEP_VAL : rem_i;
      sgn_q <= sgn_i;
    end
  end

  assign rem_o = rem_q;
  assign sgn_o = sgn_q;

endmodule

>>> rtl/core/gcd_cordic_cell.sv
// One CORDIC micro-rotation, in rotation or vectoring mode, with a passed-along sideband.
module gcd_cordic_cell
  import gcd_pkg::*;
#(
  parameter int unsigned STEP   = 0,
  parameter bit          VECTOR = 1'b0,
  parameter int unsigned XW     = RW,
  parameter int unsigned SW     = 1
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  input  logic [SW-1:0]        side_i,
  output logic signed [XW-1:0] x_o,
  output logic signed [XW-1:0] y_o,
  output logic signed [ZW-1:0] z_o,
  output logic [SW-1:0]        side_o
);

  localparam logic signed [ZW-1:0] ATAN = atan_q32(STEP);

  logic                 up;
  logic signed [XW-1:0] x_d, y_d;
  logic signed [ZW-1:0] z_d;
  logic signed [XW-1:0] x_q, y_q;
  logic signed [ZW-1:0] z_q;
  logic [SW-1:0]        side_q;

  // rotate toward zero angle, or toward zero y when vectoring
  assign up = VECTOR ? y_i[XW-1] : !z_i[ZW-1];

  always_comb begin
    if (up) begin
      x_d = x_i - (y_i >>> STEP);
      y_d = y_i + (x_i >>> STEP);
      z_d = z_i - ATAN;
    end else begin
      x_d = x_i + (y_i >>> STEP);
      y_d = y_i - (x_i >>> STEP);
      z_d = z_i + ATAN;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      side_q <= side_i;
    end
  end

  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;
  assign side_o = side_q;

endmodule

>>> rtl/core/gcd_sincos.sv
// Pipelined sine and cosine lane: angle reduction, quadrant fold and a chain of rotation cells.
module gcd_sincos
  import gcd_pkg::*;
#(
  parameter int unsigned AW    = 37,
  parameter int unsigned QB    = 2,
  parameter int unsigned STEPS = CORDIC_STEPS_DEF
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [AW-1:0] theta_i,
  output logic signed [RW-1:0] sin_o,
  output logic signed [RW-1:0] cos_o
);

  logic [AW-1:0]        mag_q;
  logic                 sgn_q;
  logic [AW-1:0]        rem_c [0:QB];
  logic                 sgn_c [0:QB];
  logic signed [ZW-1:0] t_q;
  logic signed [ZW-1:0] wrap_q;
  logic signed [ZW-1:0] fold_q;
  logic                 neg_q;
  logic signed [RW-1:0] x_c [0:STEPS];
  logic signed [RW-1:0] y_c [0:STEPS];
  logic signed [ZW-1:0] z_c [0:STEPS];
  logic                 n_c [0:STEPS];
  logic signed [RW-1:0] sin_q, cos_q;

  // split the angle into magnitude and sign
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q <= theta_i[AW-1] ? AW'(-theta_i) : AW'(theta_i);
      sgn_q <= theta_i[AW-1];
    end
  end

  assign rem_c[0] = mag_q;
  assign sgn_c[0] = sgn_q;

  // remove multiples of two pi, largest first
  for (genvar k = 0; k < QB; k++) begin : g_mod
    gcd_mod_cell #(
      .W    (AW),
      .SHIFT(QB - 1 - k)
    ) u_mod (
      .clk_i(clk_i),
      .en_i (en_i),
      .rem_i(rem_c[k]),
      .sgn_i(sgn_c[k]),
      .rem_o(rem_c[k+1]),
      .sgn_o(sgn_c[k+1])
    );
  end

  // restore the sign of the remainder
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q <= sgn_c[QB] ? -$signed(ZW'(rem_c[QB])) : $signed(ZW'(rem_c[QB]));
    end
  end

  // wrap into [-pi, pi]
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (t_q > PI_Q32) begin
        wrap_q <= t_q - TWO_PI_Q32;
      end else if (t_q < -PI_Q32) begin
        wrap_q <= t_q + TWO_PI_Q32;
      end else begin
        wrap_q <= t_q;
      end
    end
  end

  // fold into [-pi/2, pi/2]; the outer half-turn flips both results
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (wrap_q > HALF_PI_Q32) begin
        fold_q <= wrap_q - PI_Q32;
        neg_q  <= 1'b1;
      end else if (wrap_q < -HALF_PI_Q32) begin
        fold_q <= wrap_q + PI_Q32;
        neg_q  <= 1'b1;
      end else begin
        fold_q <= wrap_q;
        neg_q  <= 1'b0;
      end
    end
  end

  assign x_c[0] = RW'(INV_GAIN_Q30);
  assign y_c[0] = '0;
  assign z_c[0] = fold_q;
  assign n_c[0] = neg_q;

  for (genvar i = 0; i < STEPS; i++) begin : g_rot
    gcd_cordic_cell #(
      .STEP  (i),
      .VECTOR(1'b0),
      .XW    (RW),
      .SW    (1)
    ) u_cell (
      .clk_i (clk_i),
      .en_i  (en_i),
      .x_i   (x_c[i]),
      .y_i   (y_c[i]),
      .z_i   (z_c[i]),
      .side_i(n_c[i]),
      .x_o   (x_c[i+1]),
      .y_o   (y_c[i+1]),
      .z_o   (z_c[i+1]),
      .side_o(n_c[i+1])
    );
  end

  // apply the half-turn flip
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_q <= n_c[STEPS] ? -x_c[STEPS] : x_c[STEPS];
      sin_q <= n_c[STEPS] ? -y_c[STEPS] : y_c[STEPS];
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

>>> rtl/core/great_circle_distance_azimuth.sv
// Great-circle distance and initial azimuth between two points, as a fully pipelined CORDIC chain.
// Takes one point pair per clock and delivers one result per clock in the same order, while
// neither side is stalled. A transaction reaches the output through three chains of CORDIC
// cells in series: the sine/cosine lanes, the azimuth vectoring chain and the central angle
// vectoring chain, plus the two-pi reduction cells and the product stages. A stalled output
// holds its transaction while one more result lands in a skid register; the input stall is
// the registered skid-full flag. The radius register is read at the last stage, so write it
// only while no transaction is in flight.
module great_circle_distance_azimuth
  import gcd_pkg::*;
#(
  parameter int unsigned ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
  parameter int unsigned CORDIC_STEPS    = CORDIC_STEPS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  gcd_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output gcd_out_t            out_data_o,
  input  logic                cfg_we_i,
  input  logic [RADIUS_W-1:0] cfg_wdata_i
);

  localparam int unsigned SH = 32 - ANGLE_FRAC_BITS;
  localparam int unsigned AW = 34 + SH;
  localparam int unsigned QB = SH - 1;
  localparam int unsigned LS = QB + CORDIC_STEPS + 5;
  localparam int unsigned NV = LS + 2 * CORDIC_STEPS + 7;
  localparam logic signed [ZW-1:0] AZ_RND = ZW'(1) <<< (SH - 1);
  localparam logic signed [ZW-1:0] PI_OUT = (PI_Q32 + AZ_RND) >>> SH;

  logic                en;
  logic [NV-1:0]       vld_q;
  logic [RADIUS_W-1:0] radius_q;

  logic signed [AW-1:0] th1_q, th2_q, thd_q;
  logic signed [RW-1:0] s1, c1, s2, c2, sd, cd;

  logic signed [VW-1:0] s1s2_q, c1s2_q, c2cd_q, east_q, s1_q, c1_q;
  logic signed [VW-1:0] cosc_q, fac_q, east2_q;

  logic signed [VW-1:0] v1x [0:CORDIC_STEPS];
  logic signed [VW-1:0] v1y [0:CORDIC_STEPS];
  logic signed [ZW-1:0] v1z [0:CORDIC_STEPS];
  logic [VW:0]          v1s [0:CORDIC_STEPS];

  logic signed [VW-1:0] sinc_q, cosc2_q;
  logic signed [COORD_W-1:0] az_q;
  logic signed [ZW-1:0] az_raw, az_sum, az_rnd;

  logic signed [VW-1:0] v2x [0:CORDIC_STEPS];
  logic signed [VW-1:0] v2y [0:CORDIC_STEPS];
  logic signed [ZW-1:0] v2z [0:CORDIC_STEPS];
  logic [COORD_W:0]     v2s [0:CORDIC_STEPS];

  logic [CW-1:0]             cen_q;
  logic signed [COORD_W-1:0] azc_q;
  logic signed [ZW-1:0]      cen_raw;
  logic [CW+RADIUS_W-1:0]    prod;
  gcd_out_t                  res;

  logic     out_vld_q, skid_vld_q;
  gcd_out_t out_q, skid_q;
  logic     inc;

  // advance the whole chain unless the skid register is occupied
  assign en         = !skid_vld_q;
  assign in_stall_o = skid_vld_q;

  // hold the sphere radius
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RESET;
    end else if (cfg_we_i) begin
      radius_q <= cfg_wdata_i;
    end
  end

  // track which stages hold a transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NV-2:0], in_valid_i};
    end
  end

  // scale the inputs to Q.32 angles
  always_ff @(posedge clk_i) begin
    if (en) begin
      th1_q <= AW'(in_data_i.start_lat) <<< SH;
      th2_q <= AW'(in_data_i.end_lat) <<< SH;
      thd_q <= (AW'(in_data_i.end_lon) - AW'(in_data_i.start_lon)) <<< SH;
    end
  end

  gcd_sincos #(.AW(AW), .QB(QB), .STEPS(CORDIC_STEPS)) u_lat1 (
    .clk_i(clk_i), .en_i(en), .theta_i(th1_q), .sin_o(s1), .cos_o(c1)
  );

  gcd_sincos #(.AW(AW), .QB(QB), .STEPS(CORDIC_STEPS)) u_lat2 (
    .clk_i(clk_i), .en_i(en), .theta_i(th2_q), .sin_o(s2), .cos_o(c2)
  );

  gcd_sincos #(.AW(AW), .QB(QB), .STEPS(CORDIC_STEPS)) u_dlon (
    .clk_i(clk_i), .en_i(en), .theta_i(thd_q), .sin_o(sd), .cos_o(cd)
  );

  // first products of the spherical relations
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1s2_q <= mulq(VW'(s1), VW'(s2));
      c1s2_q <= mulq(VW'(c1), VW'(s2));
      c2cd_q <= mulq(VW'(c2), VW'(cd));
      east_q <= mulq(VW'(c2), VW'(sd));
      s1_q   <= VW'(s1);
      c1_q   <= VW'(c1);
    end
  end

  // cosine of the central angle and the northward factor
  always_ff @(posedge clk_i) begin
    if (en) begin
      cosc_q  <= s1s2_q + mulq(c1_q, c2cd_q);
      fac_q   <= c1s2_q - mulq(s1_q, c2cd_q);
      east2_q <= east_q;
    end
  end

  // set up the azimuth vector in the right half-plane, flag a near-zero vector
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (fac_q < 0) begin
        v1x[0] <= -fac_q;
        v1y[0] <= -east2_q;
        v1z[0] <= (east2_q >= 0) ? PI_Q32 : -PI_Q32;
      end else begin
        v1x[0] <= fac_q;
        v1y[0] <= east2_q;
        v1z[0] <= '0;
      end
      v1s[0] <= {cosc_q, (east2_q <= AZ_TOL) && (east2_q >= -AZ_TOL) &&
                         (fac_q <= AZ_TOL) && (fac_q >= -AZ_TOL)};
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec_az
    gcd_cordic_cell #(
      .STEP  (i),
      .VECTOR(1'b1),
      .XW    (VW),
      .SW    (VW + 1)
    ) u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .x_i   (v1x[i]),
      .y_i   (v1y[i]),
      .z_i   (v1z[i]),
      .side_i(v1s[i]),
      .x_o   (v1x[i+1]),
      .y_o   (v1y[i+1]),
      .z_o   (v1z[i+1]),
      .side_o(v1s[i+1])
    );
  end

  // round the azimuth to the output format and clamp to +-pi
  always_comb begin
    az_raw = v1s[CORDIC_STEPS][0] ? '0 : v1z[CORDIC_STEPS];
    az_sum = az_raw + AZ_RND;
    az_rnd = az_sum >>> SH;
    if (az_rnd > PI_OUT) begin
      az_rnd = PI_OUT;
    end
    if (az_rnd < -PI_OUT) begin
      az_rnd = -PI_OUT;
    end
  end

  // remove the CORDIC gain from the magnitude
  always_ff @(posedge clk_i) begin
    if (en) begin
      sinc_q  <= mulq(v1x[CORDIC_STEPS], INV_GAIN_Q30);
      cosc2_q <= v1s[CORDIC_STEPS][VW:1];
      az_q    <= COORD_W'(az_rnd);
    end
  end

  // set up the central angle vector, flag the zero vector
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (cosc2_q < 0) begin
        v2x[0] <= -cosc2_q;
        v2y[0] <= -sinc_q;
        v2z[0] <= (sinc_q >= 0) ? PI_Q32 : -PI_Q32;
      end else begin
        v2x[0] <= cosc2_q;
        v2y[0] <= sinc_q;
        v2z[0] <= '0;
      end
      v2s[0] <= {az_q, (cosc2_q == '0) && (sinc_q == '0)};
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec_cen
    gcd_cordic_cell #(
      .STEP  (i),
      .VECTOR(1'b1),
      .XW    (VW),
      .SW    (COORD_W + 1)
    ) u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .x_i   (v2x[i]),
      .y_i   (v2y[i]),
      .z_i   (v2z[i]),
      .side_i(v2s[i]),
      .x_o   (v2x[i+1]),
      .y_o   (v2y[i+1]),
      .z_o   (v2z[i+1]),
      .side_o(v2s[i+1])
    );
  end

  // clamp the central angle to [0, pi]
  always_comb begin
    cen_raw = v2s[CORDIC_STEPS][0] ? '0 : v2z[CORDIC_STEPS];
    if (cen_raw < 0) begin
      cen_raw = '0;
    end
    if (cen_raw > PI_Q32) begin
      cen_raw = PI_Q32;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cen_q <= CW'(cen_raw);
      azc_q <= v2s[CORDIC_STEPS][COORD_W:1];
    end
  end

  // scale by the radius and round to whole meters
  always_comb begin
    prod = (CW + RADIUS_W)'(cen_q) * (CW + RADIUS_W)'(radius_q) +
           ((CW + RADIUS_W)'(1) << 31);
    res.path_distance_m = DIST_W'(prod >> 32);
    res.initial_azimuth = azc_q;
  end

  assign inc = en && vld_q[NV-1];

  // output register with one skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (!out_vld_q || !out_stall_i) begin
      if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q <= inc;
      end
    end else if (inc) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || !out_stall_i) begin
      out_q <= skid_vld_q ? skid_q : res;
    end else if (inc) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

>>> rtl/core/gcd_checker.sv
// Port-level checks of the great-circle block, bound to the top level.
module gcd_checker
  import gcd_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input gcd_out_t out_data_o
);

  // a stalled transaction stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output transaction dropped while stalled");

  // a stalled transaction keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("output payload changed while stalled");

  // the input only stalls behind a held output
  a_stall_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with an empty output");

  // the input stall rises only after the output was held
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stall without a held output");

  // the clamped central angle bounds the distance
  a_dist_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.path_distance_m <= MAX_DIST)
    else $error("distance beyond half the largest circumference");

endmodule

bind great_circle_distance_azimuth gcd_checker u_gcd_checker (.*);
